### hdl/trace_cache_set_assoc_lru_assert.svh
// ----------------------------------------------------------------------------
// trace cache assertion macros
// shared assertion forms for the trace cache checkers
// ----------------------------------------------------------------------------
`ifndef TRACE_CACHE_SET_ASSOC_LRU_ASSERT_SVH
`define TRACE_CACHE_SET_ASSOC_LRU_ASSERT_SVH

// same-cycle implication
`define TCSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tcsa_pkg.sv
// ----------------------------------------------------------------------------
// tcsa_pkg
// types, codes and key helper for the set-associative trace cache
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcsa_pkg;

    typedef enum logic [1:0] {
        OP_PROBE = 2'd0,
        OP_READ  = 2'd1,
        OP_FILL  = 2'd2
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] trace_pc;
        logic [7:0]  branch_flags;
        logic [63:0] fill_payload;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [1:0]  way_used;
        logic [63:0] read_payload;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_MUL,
        ST_RD,
        ST_UPD
    } t_state;

    localparam logic [3:0] BRANCH_BITS_RST = 4'd3;
    localparam logic [3:0] BRANCH_BITS_MAX = 4'd8;

    // low key bits come from the branch flags
    function automatic logic [31:0] make_key(
        input logic [31:0] pc,
        input logic [7:0]  flags,
        input logic [3:0]  bb
    );
        logic [3:0] nb;
        logic [8:0] span;
        logic [7:0] m;
        nb   = (bb > BRANCH_BITS_MAX) ? BRANCH_BITS_MAX : bb;
        span = (9'd1 << nb) - 9'd1;
        m    = span[7:0];
        make_key = {pc[31:8], (pc[7:0] & ~m) | (flags & m)};
    endfunction

endpackage

### hdl/trace_cache_set_assoc_lru.sv
// ----------------------------------------------------------------------------
// trace_cache_set_assoc_lru
// set-associative trace cache with true lru, state held in two set memories
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  request   in         i_req_valid / o_req_ready    i_req (tcsa_pkg::t_req)
//  response  out        o_rsp_valid / i_rsp_ready    o_rsp (tcsa_pkg::t_rsp)
//  config    in         i_cfg_we                     i_cfg_wdata (branch_bits)
//
//  when SET_COUNT is a power of two the set is read as a request is taken,
//  then compared and written back in ST_UPD; otherwise the set index is
//  first formed through the reciprocal multiplier in ST_MUL and the set read
//  in ST_RD. one request is in flight at a time. after reset a clearing pass
//  writes every row of the lru/valid memory; o_req_ready stays low meanwhile.
//  a held response does not block acceptance; the next write-back waits for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trace_cache_set_assoc_lru #(
    parameter int SET_COUNT    = 64,
    parameter int WAY_COUNT    = 4,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [3:0]      i_cfg_wdata,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  tcsa_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output tcsa_pkg::t_rsp  o_rsp
);

    localparam int SB = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int WB = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam bit IS_POW2 = ((SET_COUNT & (SET_COUNT - 1)) == 0);
    localparam logic [SB-1:0] LAST_SET = SB'(SET_COUNT - 1);
    localparam logic [31:0]   SET_MASK = 32'(SET_COUNT - 1);

    typedef struct packed {
        logic [WAY_COUNT-1:0]         valid;
        logic [WAY_COUNT-1:0][WB-1:0] order;
    } t_meta_row;

    typedef struct packed {
        logic [WAY_COUNT-1:0][31:0]             tag;
        logic [WAY_COUNT-1:0][PAYLOAD_BITS-1:0] pay;
    } t_data_row;

    function automatic logic [1:0] way_bits(input logic [WB-1:0] w);
        logic [31:0] x;
        x = 32'(w);
        return x[1:0];
    endfunction

    t_meta_row r_meta_mem [SET_COUNT];
    t_data_row r_data_mem [SET_COUNT];

    tcsa_pkg::t_state  r_state;
    tcsa_pkg::t_state  n_state;
    logic [SB-1:0]     r_clr_cnt;
    logic [3:0]        r_branch_bits;
    logic [31:0]       r_key;
    tcsa_pkg::t_opcode r_op;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [SB-1:0]     r_idx;
    t_meta_row         r_meta_q;
    t_data_row         r_data_q;
    logic              r_rsp_valid;
    tcsa_pkg::t_rsp    r_rsp;

    logic              w_req_acc;
    logic [31:0]       w_in_key;
    logic [SB-1:0]     w_in_idx;
    logic [SB-1:0]     w_div_idx;
    logic [SB-1:0]     w_rd_addr;
    logic [SB-1:0]     w_wr_addr;
    logic              w_rd_en;
    logic              w_out_free;
    logic              w_meta_we;
    logic              w_data_we;
    logic              w_rsp_load;
    t_meta_row         w_meta_rst;
    t_meta_row         w_meta_new;
    t_meta_row         w_meta_wdata;
    t_data_row         w_data_new;
    logic              w_hit;
    logic [WB-1:0]     w_hit_way;
    logic              w_inv_found;
    logic [WB-1:0]     w_inv_way;
    logic [WB-1:0]     w_fill_way;
    logic [WB-1:0]     w_sel_way;
    logic [WB-1:0]     w_pos;
    logic              w_upd_meta;
    logic              w_upd_data;
    tcsa_pkg::t_rsp    w_rsp_new;

    // request side
    assign w_req_acc  = i_req_valid && o_req_ready;
    assign w_in_key   = tcsa_pkg::make_key(i_req.trace_pc, i_req.branch_flags, r_branch_bits);
    assign w_in_idx   = SB'(w_in_key & SET_MASK);
    assign w_out_free = !r_rsp_valid || i_rsp_ready;

    // set index of the held key
    if (IS_POW2) begin : g_mask
        assign w_div_idx = SB'(r_key & SET_MASK);
    end else begin : g_recip
        localparam int L     = $clog2(SET_COUNT);
        localparam int SHIFT = 32 + L;
        localparam logic [63:0] RECIP =
            ((64'd1 << SHIFT) + 64'(SET_COUNT) - 64'd1) / 64'(SET_COUNT);
        logic [64:0] r_prod;
        logic [31:0] w_quot;
        logic [31:0] w_qn;
        logic [31:0] w_rem;

        always_ff @(posedge i_clk) begin
            if (r_state == tcsa_pkg::ST_MUL) begin
                r_prod <= 65'(r_key) * 65'(RECIP[32:0]);
            end
        end

        assign w_quot    = 32'(r_prod >> SHIFT);
        assign w_qn      = w_quot * 32'(SET_COUNT);
        assign w_rem     = r_key - w_qn;
        assign w_div_idx = w_rem[SB-1:0];
    end

    // reset row: nothing valid, ways in descending order
    always_comb begin
        w_meta_rst.valid = '0;
        for (int i = 0; i < WAY_COUNT; i++) begin
            w_meta_rst.order[i] = WB'(WAY_COUNT - 1 - i);
        end
    end

    // tag compare and victim choice
    always_comb begin
        w_hit       = 1'b0;
        w_hit_way   = '0;
        w_inv_found = 1'b0;
        w_inv_way   = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            if (r_meta_q.valid[w] && (r_data_q.tag[w] == r_key)) begin
                w_hit     = 1'b1;
                w_hit_way = WB'(w);
            end
            if (!r_meta_q.valid[w]) begin
                w_inv_found = 1'b1;
                w_inv_way   = WB'(w);
            end
        end
        w_fill_way = w_inv_found ? w_inv_way : r_meta_q.order[WAY_COUNT-1];
        w_sel_way  = (r_op == tcsa_pkg::OP_FILL) ? w_fill_way : w_hit_way;
    end

    // move selected way to the front of the recency list
    always_comb begin
        w_pos = WB'(WAY_COUNT - 1);
        for (int i = WAY_COUNT - 1; i >= 0; i--) begin
            if (r_meta_q.order[i] == w_sel_way) begin
                w_pos = WB'(i);
            end
        end
        w_meta_new          = r_meta_q;
        w_meta_new.order[0] = w_sel_way;
        for (int i = 1; i < WAY_COUNT; i++) begin
            if (WB'(i) <= w_pos) begin
                w_meta_new.order[i] = r_meta_q.order[i-1];
            end
        end
        if (r_op == tcsa_pkg::OP_FILL) begin
            w_meta_new.valid[w_sel_way] = 1'b1;
        end
        w_data_new                = r_data_q;
        w_data_new.tag[w_sel_way] = r_key;
        w_data_new.pay[w_sel_way] = r_payload;
    end

    // response and write-back decode
    always_comb begin
        w_rsp_new  = '0;
        w_upd_meta = 1'b0;
        w_upd_data = 1'b0;
        unique case (r_op)
            tcsa_pkg::OP_PROBE: begin
                if (w_hit) begin
                    w_rsp_new.hit      = 1'b1;
                    w_rsp_new.way_used = way_bits(w_hit_way);
                end
            end
            tcsa_pkg::OP_READ: begin
                if (w_hit) begin
                    w_rsp_new.hit          = 1'b1;
                    w_rsp_new.way_used     = way_bits(w_hit_way);
                    w_rsp_new.read_payload = 64'(r_data_q.pay[w_hit_way]);
                    w_upd_meta             = 1'b1;
                end
            end
            tcsa_pkg::OP_FILL: begin
                w_rsp_new.way_used = way_bits(w_fill_way);
                w_upd_meta         = 1'b1;
                w_upd_data         = 1'b1;
            end
            default: begin
                w_rsp_new = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcsa_pkg::ST_CLR: begin
                if (r_clr_cnt == LAST_SET) begin
                    n_state = tcsa_pkg::ST_IDLE;
                end
            end
            tcsa_pkg::ST_IDLE: begin
                if (w_req_acc) begin
                    n_state = IS_POW2 ? tcsa_pkg::ST_UPD : tcsa_pkg::ST_MUL;
                end
            end
            tcsa_pkg::ST_MUL: begin
                n_state = tcsa_pkg::ST_RD;
            end
            tcsa_pkg::ST_RD: begin
                n_state = tcsa_pkg::ST_UPD;
            end
            tcsa_pkg::ST_UPD: begin
                if (w_out_free) begin
                    n_state = tcsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcsa_pkg::ST_CLR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_req_ready = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = w_div_idx;
        w_meta_we   = 1'b0;
        w_data_we   = 1'b0;
        w_rsp_load  = 1'b0;
        unique case (r_state)
            tcsa_pkg::ST_CLR: begin
                w_meta_we = 1'b1;
            end
            tcsa_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                w_rd_en     = i_req_valid && IS_POW2;
                w_rd_addr   = w_in_idx;
            end
            tcsa_pkg::ST_MUL: begin
                w_rd_en = 1'b0;
            end
            tcsa_pkg::ST_RD: begin
                w_rd_en = 1'b1;
            end
            tcsa_pkg::ST_UPD: begin
                w_rsp_load = w_out_free;
                w_meta_we  = w_out_free && w_upd_meta;
                w_data_we  = w_out_free && w_upd_data;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    assign w_wr_addr    = (r_state == tcsa_pkg::ST_CLR) ? r_clr_cnt : r_idx;
    assign w_meta_wdata = (r_state == tcsa_pkg::ST_CLR) ? w_meta_rst : w_meta_new;

    // set memories
    always_ff @(posedge i_clk) begin
        if (w_meta_we) begin
            r_meta_mem[w_wr_addr] <= w_meta_wdata;
        end
        if (w_data_we) begin
            r_data_mem[r_idx] <= w_data_new;
        end
        if (w_rd_en) begin
            r_meta_q <= r_meta_mem[w_rd_addr];
            r_data_q <= r_data_mem[w_rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tcsa_pkg::ST_CLR;
            r_clr_cnt     <= '0;
            r_branch_bits <= tcsa_pkg::BRANCH_BITS_RST;
            r_rsp_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tcsa_pkg::ST_CLR) begin
                r_clr_cnt <= SB'(r_clr_cnt + 1'b1);
            end
            if (i_cfg_we) begin
                r_branch_bits <= i_cfg_wdata;
            end
            if (w_rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // request and response payload
    always_ff @(posedge i_clk) begin
        if (w_req_acc) begin
            r_key     <= w_in_key;
            r_op      <= i_req.opcode;
            r_payload <= i_req.fill_payload[PAYLOAD_BITS-1:0];
        end
        if (w_rd_en) begin
            r_idx <= w_rd_addr;
        end
        if (w_rsp_load) begin
            r_rsp <= w_rsp_new;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

### hdl/tcsa_chk.sv
// ----------------------------------------------------------------------------
// tcsa_chk
// port-level checks for the trace cache, attached by bind
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "trace_cache_set_assoc_lru_assert.svh"

module tcsa_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_ready,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input tcsa_pkg::t_rsp i_rsp
);

    // stalled response holds
    `TCSA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp), "response changed while stalled")

    // payload only on a hit
    `TCSA_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, i_rsp_valid && !i_rsp.hit, i_rsp.read_payload == 64'd0, "payload without hit")

    // one request in flight
    `TCSA_ASSERT_NEXT(a_one_req, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "ready right after a request")

endmodule

bind trace_cache_set_assoc_lru tcsa_chk u_tcsa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .i_req_ready (o_req_ready),
    .i_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .i_rsp       (o_rsp)
);
